// ----- hw/rtl/bsmfd_pkg.sv -----
package bsmfd_pkg;

	// Item commands
	typedef enum logic [1:0] {
		CMD_FRAME_START = 2'd0,
		CMD_STORE       = 2'd1,
		CMD_FETCH       = 2'd2,
		CMD_FRAME_END   = 2'd3
	} cmd_t;

	// Register indexes on the configuration port (byte address = 8 * index)
	localparam logic [1:0] REG_FRAME_PIXELS = 2'd0;
	localparam logic [1:0] REG_BEAT_MODE    = 2'd1;
	localparam logic [1:0] REG_DELAY_TABLE  = 2'd2;

	localparam int CMD_W     = 2;
	localparam int SEL_W     = 3;
	localparam int IDX_W     = 16;
	localparam int PIX_W     = 32;
	localparam int FP_CFG_W  = 17;
	localparam int MASK_W    = 6;
	localparam int TABLE_W   = 36;
	localparam int FIELD_W   = 6;
	localparam int FIELDS    = 6;
	localparam int EDW       = 17;
	localparam int BEAT_W    = 16;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 64;

	localparam logic [FIELD_W-1:0] DELAY_LIMIT = 6'd60;

	// Clamp a set delay field and add the current frame
	function automatic logic [EDW-1:0] delay_plus_one(input logic [FIELD_W-1:0] f);
		logic [FIELD_W-1:0] c;
		c = (f > DELAY_LIMIT) ? DELAY_LIMIT : f;
		return EDW'(c) + EDW'(1);
	endfunction

endpackage

// ----- hw/rtl/beat_synced_multi_frame_delay.sv -----
// Frame delay with BUFFERS ring buffers held in one pixel memory of BUFFERS * WORDS_PER_BUFFER
// words. After reset the block clears that memory, one word per cycle, and stalls its input
// meanwhile; configuration writes are taken throughout. Items are handled one at a time by a
// small sequencer. After it takes a transaction the input stalls while the sequencer steps
// through ST_ACC and ST_MEM on a store, those and ST_OUT on a fetch plus any wait for the
// output register to free up, ST_FE on a frame end (one position update per buffer), and on a
// frame start ST_FS_BEAT, then ST_FS_MUL and ST_FS_UPD for each buffer in turn, sharing the
// single delay-times-frame-size multiplier, with its product registered before the resize
// compare; the idle cycle that follows takes the next transaction. A new item is taken while a
// fetched pixel still waits at the output.
module beat_synced_multi_frame_delay #(
	parameter int BUFFERS          = 6,
	parameter int WORDS_PER_BUFFER = 262144,
	parameter int MAX_FRAME_PIXELS = 65536
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// item input
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bsmfd_pkg::CMD_W-1:0]         cmd,
	input  logic                                beat,
	input  logic [bsmfd_pkg::SEL_W-1:0]         buffer_select,
	input  logic [bsmfd_pkg::IDX_W-1:0]         pixel_index,
	input  logic [bsmfd_pkg::PIX_W-1:0]         pixel_in,
	// result output
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bsmfd_pkg::PIX_W-1:0]         pixel_out,
	output logic                                from_store,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bsmfd_pkg::PADDR_W-1:0]       paddr,
	input  logic [bsmfd_pkg::PDATA_W-1:0]       pwdata,
	output logic [bsmfd_pkg::PDATA_W-1:0]       prdata,
	output logic                                pready
);

	localparam int EDW    = bsmfd_pkg::EDW;
	localparam int BW     = bsmfd_pkg::BEAT_W;
	localparam int PXW    = bsmfd_pkg::PIX_W;
	localparam int FW     = bsmfd_pkg::FIELD_W;
	localparam int IW     = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
	localparam int FPW    = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int CMPW   = (FPW > bsmfd_pkg::FP_CFG_W) ? FPW : bsmfd_pkg::FP_CFG_W;
	localparam int PW     = $clog2(WORDS_PER_BUFFER);
	localparam int RW     = $clog2(WORDS_PER_BUFFER + 1);
	localparam int SUMW   = ((PW > FPW) ? PW : FPW) + 1;
	localparam int PRW    = EDW + FPW;
	localparam int DEPTH  = BUFFERS * WORDS_PER_BUFFER;
	localparam int AW     = $clog2(DEPTH);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FS_BEAT,
		ST_FS_MUL,
		ST_FS_UPD,
		ST_FE,
		ST_ACC,
		ST_MEM,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [bsmfd_pkg::FP_CFG_W-1:0] fp_cfg_q;
	logic [bsmfd_pkg::MASK_W-1:0]   mask_q;
	logic [bsmfd_pkg::TABLE_W-1:0]  table_q;

	// per-buffer and beat state
	logic [BW-1:0]  fsb_q;
	logic [BW-1:0]  beat_period_q;
	logic [EDW-1:0] ed_q   [BUFFERS];
	logic [RW-1:0]  ring_q [BUFFERS];
	logic [PW-1:0]  wp_q   [BUFFERS];
	logic [PW-1:0]  rp_q   [BUFFERS];
	logic [FPW-1:0] last_fp_q;

	// sequencer working registers
	logic [IW-1:0]                  cur_q;
	logic [AW-1:0]                  clr_q;
	logic [PRW-1:0]                 prod_q;
	bsmfd_pkg::cmd_t                cmd_q;
	logic                           beat_q;
	logic [bsmfd_pkg::SEL_W-1:0]    sel_q;
	logic [bsmfd_pkg::IDX_W-1:0]    idx_q;
	logic [PXW-1:0]                 pix_q;
	logic                           act_q;
	logic [AW-1:0]                  addr_q;
	logic [PXW-1:0]                 rd_q;

	// output registers
	logic            out_valid_q;
	logic [PXW-1:0]  pixel_out_q;
	logic            from_store_q;

	// memory port
	logic [PXW-1:0] mem [DEPTH];
	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [PXW-1:0] mem_wdata;

	// derived values
	logic [63:0]    mode_pad;
	logic [63:0]    table_pad;
	logic [CMPW-1:0] fp_wide;
	logic [FPW-1:0] fp;
	logic [EDW-1:0] ed_cur;
	logic [RW-1:0]  ring_cur;
	logic [PW-1:0]  wp_cur;
	logic [PW-1:0]  rp_cur;
	logic [EDW-1:0] bp_inc;
	logic [SUMW-1:0] wp_sum;
	logic [SUMW-1:0] rp_sum;
	logic [PW-1:0]  wp_adv;
	logic [PW-1:0]  rp_adv;
	logic [PW-1:0]  acc_pos;
	logic [SUMW-1:0] acc_end;
	logic           acc_active;
	logic [AW-1:0]  acc_addr;
	logic           cfg_wr;

	// used frame size: zero reads as one, clamp at the maximum
	assign fp_wide = CMPW'(fp_cfg_q);
	always_comb begin
		if (fp_wide == '0) begin
			fp = FPW'(1);
		end else if (fp_wide > CMPW'(MAX_FRAME_PIXELS)) begin
			fp = FPW'(MAX_FRAME_PIXELS);
		end else begin
			fp = FPW'(fp_wide);
		end
	end

	assign mode_pad  = 64'(mask_q);
	assign table_pad = 64'(table_q);
	assign bp_inc    = EDW'(beat_period_q) + EDW'(1);

	// state of the buffer under the sequencer
	assign ed_cur   = ed_q[cur_q];
	assign ring_cur = ring_q[cur_q];
	assign wp_cur   = wp_q[cur_q];
	assign rp_cur   = rp_q[cur_q];

	// advance positions by one frame and wrap at the ring size
	assign wp_sum = SUMW'(wp_cur) + SUMW'(fp);
	assign rp_sum = SUMW'(rp_cur) + SUMW'(fp);
	assign wp_adv = (wp_sum >= SUMW'(ring_cur)) ? '0 : PW'(wp_sum);
	assign rp_adv = (rp_sum >= SUMW'(ring_cur)) ? '0 : PW'(rp_sum);

	// locate a pixel access
	assign acc_pos    = (cmd_q == bsmfd_pkg::CMD_STORE) ? wp_cur : rp_cur;
	assign acc_end    = SUMW'(acc_pos) + SUMW'(fp);
	assign acc_active = (4'(sel_q) < 4'(BUFFERS)) && (ed_cur > EDW'(1))
		&& (CMPW'(idx_q) < CMPW'(fp)) && (acc_end <= SUMW'(WORDS_PER_BUFFER));
	assign acc_addr   = AW'(cur_q) * AW'(WORDS_PER_BUFFER) + AW'(acc_pos) + AW'(idx_q);

	// configuration port
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[4:3])
			bsmfd_pkg::REG_FRAME_PIXELS: prdata = 64'(fp_cfg_q);
			bsmfd_pkg::REG_BEAT_MODE:    prdata = 64'(mask_q);
			bsmfd_pkg::REG_DELAY_TABLE:  prdata = 64'(table_q);
			default:                     prdata = '0;
		endcase
	end

	// handshake outputs
	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_out_q;
	assign from_store = from_store_q;

	// sequencer, configuration and buffer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			fp_cfg_q      <= bsmfd_pkg::FP_CFG_W'(1);
			mask_q        <= '0;
			table_q       <= '0;
			fsb_q         <= '0;
			beat_period_q <= '0;
			for (int i = 0; i < BUFFERS; i++) begin
				ed_q[i]   <= '0;
				ring_q[i] <= RW'(1);
				wp_q[i]   <= '0;
				rp_q[i]   <= '0;
			end
			last_fp_q     <= FPW'(1);
			cur_q         <= '0;
			clr_q         <= '0;
			prod_q        <= '0;
			cmd_q         <= bsmfd_pkg::CMD_FRAME_START;
			beat_q        <= 1'b0;
			sel_q         <= '0;
			idx_q         <= '0;
			pix_q         <= '0;
			act_q         <= 1'b0;
			addr_q        <= '0;
			out_valid_q   <= 1'b0;
			pixel_out_q   <= '0;
			from_store_q  <= 1'b0;
		end else begin
			// register writes; recompute delays whose mode or field changed
			if (cfg_wr) begin
				unique case (paddr[4:3])
					bsmfd_pkg::REG_FRAME_PIXELS: begin
						fp_cfg_q <= pwdata[bsmfd_pkg::FP_CFG_W-1:0];
					end
					bsmfd_pkg::REG_BEAT_MODE: begin
						mask_q <= pwdata[bsmfd_pkg::MASK_W-1:0];
						for (int i = 0; i < BUFFERS; i++) begin
							if (i < bsmfd_pkg::FIELDS && pwdata[i] != mode_pad[i]) begin
								ed_q[i] <= pwdata[i] ? bp_inc
									: bsmfd_pkg::delay_plus_one(table_pad[FW*i +: FW]);
							end
						end
					end
					bsmfd_pkg::REG_DELAY_TABLE: begin
						table_q <= pwdata[bsmfd_pkg::TABLE_W-1:0];
						for (int i = 0; i < BUFFERS; i++) begin
							if (i < bsmfd_pkg::FIELDS
								&& pwdata[FW*i +: FW] != table_pad[FW*i +: FW]) begin
								ed_q[i] <= mode_pad[i] ? bp_inc
									: bsmfd_pkg::delay_plus_one(pwdata[FW*i +: FW]);
							end
						end
					end
					default: begin
					end
				endcase
			end

			// drop the result once taken, unless a new one loads in its place
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				// sweep the pixel memory to zero
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end

				// take a transaction and dispatch on its command
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q  <= bsmfd_pkg::cmd_t'(cmd);
						beat_q <= beat;
						sel_q  <= buffer_select;
						idx_q  <= pixel_index;
						pix_q  <= pixel_in;
						unique case (bsmfd_pkg::cmd_t'(cmd))
							bsmfd_pkg::CMD_FRAME_START: begin
								state_q <= ST_FS_BEAT;
							end
							bsmfd_pkg::CMD_FRAME_END: begin
								cur_q   <= '0;
								state_q <= ST_FE;
							end
							bsmfd_pkg::CMD_STORE, bsmfd_pkg::CMD_FETCH: begin
								cur_q   <= IW'(buffer_select);
								state_q <= ST_ACC;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end

				// latch the beat period and advance the frame counter
				ST_FS_BEAT: begin
					if (beat_q) begin
						beat_period_q <= fsb_q;
						for (int i = 0; i < BUFFERS; i++) begin
							if (mode_pad[i]) begin
								ed_q[i] <= EDW'(fsb_q) + EDW'(1);
							end
						end
						fsb_q <= BW'(1);
					end else if (fsb_q != '1) begin
						fsb_q <= fsb_q + BW'(1);
					end
					cur_q   <= '0;
					state_q <= ST_FS_MUL;
				end

				// ring size of the current buffer
				ST_FS_MUL: begin
					prod_q  <= PRW'(ed_cur) * PRW'(fp);
					state_q <= ST_FS_UPD;
				end

				// resize the ring, or fail the allocation
				ST_FS_UPD: begin
					if (ed_cur > EDW'(1)
						&& !(fp == last_fp_q && prod_q == PRW'(ring_cur))) begin
						if (prod_q > PRW'(WORDS_PER_BUFFER)) begin
							ed_q[cur_q] <= '0;
							if (mode_pad[6'(cur_q)]) begin
								beat_period_q <= '0;
								fsb_q         <= '0;
								for (int j = 0; j < bsmfd_pkg::FIELDS; j++) begin
									if (j < BUFFERS && cur_q == IW'(j)) begin
										table_q[FW*j +: FW] <= '0;
									end
								end
							end
						end else begin
							ring_q[cur_q] <= RW'(prod_q);
							rp_q[cur_q]   <= '0;
							wp_q[cur_q]   <= (prod_q > PRW'(fp)) ? PW'(prod_q - PRW'(fp)) : '0;
						end
					end
					if (cur_q == IW'(BUFFERS - 1)) begin
						last_fp_q <= fp;
						state_q   <= ST_IDLE;
					end else begin
						cur_q   <= cur_q + IW'(1);
						state_q <= ST_FS_MUL;
					end
				end

				// advance positions one buffer per cycle
				ST_FE: begin
					wp_q[cur_q] <= wp_adv;
					rp_q[cur_q] <= rp_adv;
					if (cur_q == IW'(BUFFERS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						cur_q <= cur_q + IW'(1);
					end
				end

				// resolve the pixel address
				ST_ACC: begin
					act_q   <= acc_active;
					addr_q  <= acc_addr;
					state_q <= ST_MEM;
				end

				// memory write or read happens here
				ST_MEM: begin
					state_q <= (cmd_q == bsmfd_pkg::CMD_FETCH) ? ST_OUT : ST_IDLE;
				end

				// load the result when the output register is free
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						pixel_out_q  <= act_q ? rd_q : pix_q;
						from_store_q <= act_q;
						out_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// pixel memory: one write port, one registered read port
	assign mem_we    = (state_q == ST_CLEAR)
		|| (state_q == ST_MEM && cmd_q == bsmfd_pkg::CMD_STORE && act_q);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : addr_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : pix_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[addr_q];
	end

`ifndef NO_ASSERTIONS
	// rings never outgrow their share of the memory
	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FE || state_q == ST_FS_UPD) |-> ring_cur <= RW'(WORDS_PER_BUFFER))
		else $error("ring size exceeds buffer capacity");

	// positions stay inside the buffer
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FE || (state_q == ST_ACC && 4'(sel_q) < 4'(BUFFERS)))
		|-> (SUMW'(wp_cur) < SUMW'(WORDS_PER_BUFFER) && SUMW'(rp_cur) < SUMW'(WORDS_PER_BUFFER)))
		else $error("ring position outside buffer");

	// the clearing sweep walks every address in order
	a_clear_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && clr_q != AW'(DEPTH - 1))
		|=> (state_q == ST_CLEAR && clr_q == $past(clr_q) + AW'(1)))
		else $error("clearing sweep skipped or stopped early");

	// a store from an inactive buffer never reaches the memory
	a_store_guard: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q != ST_CLEAR) |-> (act_q && cmd_q == bsmfd_pkg::CMD_STORE))
		else $error("memory written by an inactive access");
`endif

endmodule
